// ----- hdl/bmpdec_pkg.sv -----
// Shared types and constants for the BMP stream decoder.
`default_nettype none

package bmpdec_pkg;

  // Size limit default and fixed header geometry
  localparam int MAX_DIM_DEF  = 2048;
  localparam int HEADER_BYTES = 54;

  // Byte offsets of the header fields that are decoded
  localparam int OFS_PIXOFF = 10;
  localparam int OFS_WIDTH  = 18;
  localparam int OFS_HEIGHT = 22;
  localparam int OFS_BPP    = 28;
  localparam int OFS_COMP   = 30;

  // File signature
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  // Supported depths
  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PIXEL,
    KIND_STATUS
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK,
    ST_SHORT,
    ST_SIGNATURE,
    ST_OFFSET,
    ST_SIZE,
    ST_DEPTH,
    ST_COMPRESSED,
    ST_OFFSET_LOW,
    ST_TRUNCATED
  } stat_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [31:0] argb;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic        alpha_present;
    stat_t       status;
    logic        done_res;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/bmpdec_out_fifo.sv -----
// Four-entry result queue that takes up to two result items per cycle.
`default_nettype none

module bmpdec_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_a,
  input  bmpdec_pkg::res_t  res_a,
  input  logic              push_b,
  input  bmpdec_pkg::res_t  res_b,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output bmpdec_pkg::res_t  out_res
);
  import bmpdec_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [PTR_W-1:0] tail_p1;

  // Room for two items, so a producer may always push a pair
  assign room      = cnt_r <= CNT_W'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign tail_p1   = tail_r + PTR_W'(1);

  // Pointer and count update
  always_comb begin
    head_nxt = pop ? head_r + PTR_W'(1) : head_r;
    tail_nxt = tail_r + PTR_W'(push_a) + PTR_W'(push_b);
    cnt_nxt  = cnt_r + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage: the first item goes to the tail, a second one right after it
  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[tail_r] <= res_a;
    end
    if (push_a && push_b) begin
      mem_r[tail_p1] <= res_b;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bmpdec_core.sv -----
// Header parser, pixel assembler and status logic, one byte per cycle while fire is high.
`default_nettype none

module bmpdec_core #(
  parameter int MAX_DIM = bmpdec_pkg::MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              header_only,
  output bmpdec_pkg::res_t  res_a,
  output logic              res_a_vld,
  output bmpdec_pkg::res_t  res_b,
  output logic              res_b_vld
);
  import bmpdec_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int RB_W  = $clog2(4 * MAX_DIM + 1);

  // Stream state
  logic [31:0]      pos_r, pos_nxt;
  logic [31:0]      poff_r, poff_nxt;
  logic [31:0]      rw_r, rw_nxt;
  logic [31:0]      rh_r, rh_nxt;
  logic [15:0]      bpp_r, bpp_nxt;
  logic [15:0]      comp_r, comp_nxt;
  phase_t           phase_r, phase_nxt, phase_upd;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [RB_W-1:0]  rbc_r, rbc_nxt;
  logic [1:0]       bip_r, bip_nxt;
  logic [23:0]      hold_r, hold_nxt;
  stat_t            err_r, err_nxt, err_upd;

  // Image geometry latched at the end of the header
  logic [DIM_W-1:0] ah_r, ah_nxt;
  logic             neg_r, neg_nxt;
  logic             a32_r, a32_nxt;
  logic [RB_W-1:0]  dbytes_r, dbytes_nxt;
  logic [RB_W-1:0]  padded_r, padded_nxt;

  // Decode terms
  logic [31:0]      ah_full;
  stat_t            hdr_stat;
  logic [DIM_W-1:0] w_trim;
  logic [RB_W-1:0]  dbytes_calc;
  logic [RB_W-1:0]  padded_calc;
  logic             hdr_end;
  logic             eff_pix;
  logic             in_data;
  logic             bip_last;
  logic             emit_pix;
  logic [RB_W-1:0]  rbc_inc;
  logic             row_end;
  logic             rows_done;
  logic [DIM_W-1:0] pix_y;
  logic [31:0]      argb;
  stat_t            fin_stat;
  res_t             prim_res;
  res_t             stat_res;

  // Header checks, from fields that are complete by the last header byte
  always_comb begin
    ah_full = rh_r[31] ? (32'd0 - rh_r) : rh_r;
    hdr_stat = err_r;
    if (err_r == ST_OK) begin
      if (rw_r == '0 || rw_r > 32'(MAX_DIM) || ah_full > 32'(MAX_DIM)) begin
        hdr_stat = ST_SIZE;
      end else if (bpp_r != BPP_24 && bpp_r != BPP_32) begin
        hdr_stat = ST_DEPTH;
      end else if (comp_r != '0) begin
        hdr_stat = ST_COMPRESSED;
      end else if (poff_r < 32'(HEADER_BYTES)) begin
        hdr_stat = ST_OFFSET_LOW;
      end
    end
    // Row geometry: bytes of pixel data and the padded row length
    w_trim      = rw_r[DIM_W-1:0];
    dbytes_calc = (bpp_r == BPP_32) ? RB_W'({w_trim, 2'b00})
                                    : RB_W'(w_trim) + RB_W'({w_trim, 1'b0});
    padded_calc = (dbytes_calc + RB_W'(3)) & ~RB_W'(3);
  end

  // Pixel-phase terms
  always_comb begin
    hdr_end   = (phase_r == PH_HEADER) && (pos_r == 32'(HEADER_BYTES - 1));
    eff_pix   = (phase_r == PH_PIXELS) || (phase_r == PH_SKIP && pos_r >= poff_r);
    in_data   = rbc_r < dbytes_r;
    bip_last  = bip_r == (a32_r ? 2'd3 : 2'd2);
    emit_pix  = eff_pix && in_data && bip_last;
    rbc_inc   = rbc_r + RB_W'(1);
    row_end   = rbc_inc >= padded_r;
    rows_done = ({1'b0, row_r} + (DIM_W + 1)'(1)) >= {1'b0, ah_r};
    pix_y     = neg_r ? row_r : (ah_r - DIM_W'(1) - row_r);
    argb      = a32_r ? {data_byte, hold_r}
                      : {ALPHA_OPAQUE, data_byte, hold_r[15:0]};
  end

  // Next state
  always_comb begin
    pos_nxt    = pos_r;
    poff_nxt   = poff_r;
    rw_nxt     = rw_r;
    rh_nxt     = rh_r;
    bpp_nxt    = bpp_r;
    comp_nxt   = comp_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rbc_nxt    = rbc_r;
    bip_nxt    = bip_r;
    hold_nxt   = hold_r;
    ah_nxt     = ah_r;
    neg_nxt    = neg_r;
    a32_nxt    = a32_r;
    dbytes_nxt = dbytes_r;
    padded_nxt = padded_r;
    phase_upd  = phase_r;
    err_upd    = err_r;

    if (fire) begin
      pos_nxt = (pos_r == '1) ? pos_r : pos_r + 32'd1;

      if (phase_r == PH_HEADER) begin
        // Signature and field capture
        if ((pos_r == 32'd0 && data_byte != SIG_B) ||
            (pos_r == 32'd1 && data_byte != SIG_M)) begin
          err_upd = ST_SIGNATURE;
        end
        for (int k = 0; k < 4; k++) begin
          if (pos_r == 32'(OFS_PIXOFF + k)) poff_nxt[8*k +: 8] = data_byte;
          if (pos_r == 32'(OFS_WIDTH + k))  rw_nxt[8*k +: 8]   = data_byte;
          if (pos_r == 32'(OFS_HEIGHT + k)) rh_nxt[8*k +: 8]   = data_byte;
        end
        for (int k = 0; k < 2; k++) begin
          if (pos_r == 32'(OFS_BPP + k))  bpp_nxt[8*k +: 8]  = data_byte;
          if (pos_r == 32'(OFS_COMP + k)) comp_nxt[8*k +: 8] = data_byte;
        end
        // End of header: verdict and row geometry
        if (hdr_end) begin
          err_upd    = hdr_stat;
          ah_nxt     = DIM_W'(ah_full);
          neg_nxt    = rh_r[31];
          a32_nxt    = bpp_r == BPP_32;
          dbytes_nxt = dbytes_calc;
          padded_nxt = padded_calc;
          if (hdr_stat != ST_OK || header_only || ah_full == '0) begin
            phase_upd = PH_TAIL;
          end else begin
            phase_upd = PH_SKIP;
          end
        end
      end else if (eff_pix) begin
        // Pixel bytes, then padding, row by row
        phase_upd = PH_PIXELS;
        if (in_data) begin
          if (bip_last) begin
            col_nxt = col_r + DIM_W'(1);
            bip_nxt = '0;
          end else begin
            hold_nxt[8*bip_r +: 8] = data_byte;
            bip_nxt = bip_r + 2'd1;
          end
        end
        rbc_nxt = rbc_inc;
        if (row_end) begin
          rbc_nxt = '0;
          col_nxt = '0;
          bip_nxt = '0;
          if (rows_done) begin
            phase_upd = PH_TAIL;
          end else begin
            row_nxt = row_r + DIM_W'(1);
          end
        end
      end
    end

    phase_nxt = phase_upd;
    err_nxt   = err_upd;

    // End of file: back to the start for the next one
    if (fire && last_byte) begin
      pos_nxt   = '0;
      phase_nxt = PH_HEADER;
      err_nxt   = ST_OK;
      col_nxt   = '0;
      row_nxt   = '0;
      rbc_nxt   = '0;
      bip_nxt   = '0;
    end
  end

  // Result items
  always_comb begin
    if (pos_r < 32'(HEADER_BYTES - 1)) begin
      fin_stat = ST_SHORT;
    end else if (err_upd == ST_SIGNATURE) begin
      fin_stat = ST_SIGNATURE;
    end else if ({1'b0, poff_r} > ({1'b0, pos_r} + 33'd1)) begin
      fin_stat = ST_OFFSET;
    end else if (err_upd != ST_OK) begin
      fin_stat = err_upd;
    end else if (phase_upd != PH_TAIL) begin
      fin_stat = ST_TRUNCATED;
    end else begin
      fin_stat = ST_OK;
    end

    stat_res          = '0;
    stat_res.kind     = KIND_STATUS;
    stat_res.status   = fin_stat;
    stat_res.done_res = 1'b1;

    prim_res = '0;
    if (hdr_end) begin
      prim_res.kind   = KIND_HEADER;
      prim_res.status = hdr_stat;
      if (hdr_stat == ST_OK) begin
        prim_res.image_width   = 12'(rw_r);
        prim_res.image_height  = 12'(ah_full);
        prim_res.alpha_present = bpp_r == BPP_32;
      end
    end else begin
      prim_res.kind    = KIND_PIXEL;
      prim_res.argb    = argb;
      prim_res.pixel_x = 11'(col_r);
      prim_res.pixel_y = 11'(pix_y);
    end

    // Status goes second when it shares the byte with another result
    res_a_vld = fire && (hdr_end || emit_pix || last_byte);
    res_a     = (hdr_end || emit_pix) ? prim_res : stat_res;
    res_b_vld = fire && (hdr_end || emit_pix) && last_byte;
    res_b     = stat_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      err_r   <= ST_OK;
      col_r   <= '0;
      row_r   <= '0;
      rbc_r   <= '0;
      bip_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rbc_r   <= rbc_nxt;
      bip_r   <= bip_nxt;
    end
  end

  // Header fields and geometry
  always_ff @(posedge clk) begin
    poff_r   <= poff_nxt;
    rw_r     <= rw_nxt;
    rh_r     <= rh_nxt;
    bpp_r    <= bpp_nxt;
    comp_r   <= comp_nxt;
    hold_r   <= hold_nxt;
    ah_r     <= ah_nxt;
    neg_r    <= neg_nxt;
    a32_r    <= a32_nxt;
    dbytes_r <= dbytes_nxt;
    padded_r <= padded_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/bmp_stream_decoder.sv -----
// Top level of the BMP stream decoder: input register, decoder core, result queue.
`default_nettype none

// Decodes an uncompressed 24- or 32-bit BMP file arriving one byte per item.
// A byte is taken every cycle unless in_stall is high; a byte passes an input
// register, is decoded combinationally and its results enter a four-entry
// queue. The header result comes with the last header byte, one pixel result
// with the last byte of each pixel, and the final status with the byte flagged
// last. Only the final byte can carry two results (pixel or header plus
// status); the queue absorbs that, and the output port sets the sustained rate
// of one result per cycle while out_stall is low. The header_only register is
// sampled at the last header byte and should be written between files.
module bmp_stream_decoder #(
  parameter int MAX_DIM = bmpdec_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_argb,
  output logic [10:0] out_pixel_x,
  output logic [10:0] out_pixel_y,
  output logic [11:0] out_image_width,
  output logic [11:0] out_image_height,
  output logic        out_alpha_present,
  output logic [3:0]  out_status,
  output logic        out_done_res
);
  import bmpdec_pkg::*;

  logic       hdr_only_r;
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       room;
  logic       fire;
  logic       accept;
  res_t       res_a, res_b, out_res;
  logic       res_a_vld, res_b_vld;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_only_r <= 1'b0;
    end else if (cfg_wr_en) begin
      hdr_only_r <= cfg_wr_data;
    end
  end

  // Input register: holds an item until the queue has room for its results
  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  bmpdec_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_data_r),
    .last_byte   (in_last_r),
    .header_only (hdr_only_r),
    .res_a       (res_a),
    .res_a_vld   (res_a_vld),
    .res_b       (res_b),
    .res_b_vld   (res_b_vld)
  );

  bmpdec_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (res_a_vld),
    .res_a     (res_a),
    .push_b    (res_b_vld),
    .res_b     (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Result fields
  assign out_kind          = out_res.kind;
  assign out_argb          = out_res.argb;
  assign out_pixel_x       = out_res.pixel_x;
  assign out_pixel_y       = out_res.pixel_y;
  assign out_image_width   = out_res.image_width;
  assign out_image_height  = out_res.image_height;
  assign out_alpha_present = out_res.alpha_present;
  assign out_status        = out_res.status;
  assign out_done_res      = out_res.done_res;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for bmp_stream_decoder: byte-stream driver, result checker and decode predictor.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpdec_pkg::*;

  localparam int          CLK_HALF     = 2;
  localparam int          SETTLE       = 8;     // cycles after drain before a mode change
  localparam int          QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int          RANDOM_BYTES = 450;
  localparam logic [15:0] SIG_OK       = {SIG_M, SIG_B};

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // DUT ports
  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [31:0] out_argb;
  logic [10:0] out_pixel_x;
  logic [10:0] out_pixel_y;
  logic [11:0] out_image_width;
  logic [11:0] out_image_height;
  logic        out_alpha_present;
  logic [3:0]  out_status;
  logic        out_done_res;

  // Stimulus and bookkeeping
  byte_item_t file_bytes[$];
  byte_item_t next_byte;
  res_t       decoded_results[$];
  int         bytes_queued;
  int         bytes_taken = 0;
  int         mismatch_count = 0;
  int         quiet_cycles;
  int         send_idle_pct;
  int         recv_idle_pct;
  logic       in_fired;

  // Decoder state mirror
  logic        hdr_only_mode;
  logic [31:0] byte_pos;
  logic [31:0] pix_offset;
  logic [31:0] raw_w;
  logic [31:0] raw_h;
  logic [15:0] depth;
  logic [15:0] comp_code;
  phase_t      dec_phase;
  logic [10:0] col_idx;
  logic [10:0] row_idx;
  logic [13:0] row_byte_cnt;
  logic [1:0]  pix_byte;
  logic [23:0] pix_hold;
  stat_t       dec_err;

  bmp_stream_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_argb          (out_argb),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_image_width   (out_image_width),
    .out_image_height  (out_image_height),
    .out_alpha_present (out_alpha_present),
    .out_status        (out_status),
    .out_done_res      (out_done_res)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Decode predictor
  // ---------------------------------------------------------------------

  function automatic logic [31:0] image_rows();
    return raw_h[31] ? -raw_h : raw_h;
  endfunction

  task automatic clear_decoder();
    byte_pos     = '0;
    pix_offset   = '0;
    raw_w        = '0;
    raw_h        = '0;
    depth        = '0;
    comp_code    = '0;
    dec_phase    = PH_HEADER;
    col_idx      = '0;
    row_idx      = '0;
    row_byte_cnt = '0;
    pix_byte     = '0;
    pix_hold     = '0;
    dec_err      = ST_OK;
  endtask

  task automatic push_result(input kind_t k, input logic [31:0] argb,
                             input logic [10:0] x, input logic [10:0] y,
                             input logic [11:0] w, input logic [11:0] h,
                             input logic alpha, input stat_t st, input logic done);
    res_t r;
    r.kind          = k;
    r.argb          = argb;
    r.pixel_x       = x;
    r.pixel_y       = y;
    r.image_width   = w;
    r.image_height  = h;
    r.alpha_present = alpha;
    r.status        = st;
    r.done_res      = done;
    decoded_results.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [31:0] pos;
    logic [31:0] rows;
    logic [31:0] bpb;
    logic [31:0] data_bytes;
    logic [31:0] padded;
    logic [31:0] argb;
    logic [31:0] y;
    stat_t       fin;
    pos = byte_pos;
    if (dec_phase == PH_HEADER) begin
      if ((pos == 0 && b != SIG_B) || (pos == 1 && b != SIG_M)) dec_err = ST_SIGNATURE;
      if (pos >= OFS_PIXOFF && pos < OFS_PIXOFF + 4)
        pix_offset |= 32'(b) << (8 * (pos - OFS_PIXOFF));
      if (pos >= OFS_WIDTH && pos < OFS_WIDTH + 4)
        raw_w |= 32'(b) << (8 * (pos - OFS_WIDTH));
      if (pos >= OFS_HEIGHT && pos < OFS_HEIGHT + 4)
        raw_h |= 32'(b) << (8 * (pos - OFS_HEIGHT));
      if (pos >= OFS_BPP && pos < OFS_BPP + 2)
        depth |= 16'(b) << (8 * (pos - OFS_BPP));
      if (pos >= OFS_COMP && pos < OFS_COMP + 2)
        comp_code |= 16'(b) << (8 * (pos - OFS_COMP));
      // Header complete: validate in priority order and report
      if (pos == HEADER_BYTES - 1) begin
        rows = image_rows();
        if (dec_err == ST_OK) begin
          if (raw_w == 0 || raw_w > MAX_DIM_DEF || rows > MAX_DIM_DEF) dec_err = ST_SIZE;
          else if (depth != BPP_24 && depth != BPP_32) dec_err = ST_DEPTH;
          else if (comp_code != 0) dec_err = ST_COMPRESSED;
          else if (pix_offset < HEADER_BYTES) dec_err = ST_OFFSET_LOW;
        end
        if (dec_err != ST_OK) begin
          push_result(KIND_HEADER, '0, '0, '0, '0, '0, 1'b0, dec_err, 1'b0);
          dec_phase = PH_TAIL;
        end else begin
          push_result(KIND_HEADER, '0, '0, '0, raw_w[11:0], rows[11:0],
                      depth == BPP_32, ST_OK, 1'b0);
          dec_phase = (hdr_only_mode || rows == 0) ? PH_TAIL : PH_SKIP;
        end
      end
    end else begin
      if (dec_phase == PH_SKIP && pos >= pix_offset) dec_phase = PH_PIXELS;
      if (dec_phase == PH_PIXELS) begin
        bpb        = 32'(depth) / 8;
        data_bytes = raw_w * bpb;
        padded     = (data_bytes + 3) & ~32'd3;
        // Pixel bytes arrive B, G, R (, A); padding bytes only advance the row
        if (32'(row_byte_cnt) < data_bytes) begin
          if (32'(pix_byte) + 1 >= bpb) begin
            if (bpb == 4) argb = {b, pix_hold};
            else argb = {ALPHA_OPAQUE, b, pix_hold[15:0]};
            rows = image_rows();
            y = raw_h[31] ? 32'(row_idx) : rows - 1 - 32'(row_idx);
            push_result(KIND_PIXEL, argb, col_idx, y[10:0], '0, '0, 1'b0, ST_OK, 1'b0);
            col_idx++;
            pix_byte = '0;
            pix_hold = '0;
          end else begin
            pix_hold = pix_hold | (24'(b) << (8 * pix_byte));
            pix_byte++;
          end
        end
        row_byte_cnt++;
        if (32'(row_byte_cnt) >= padded) begin
          row_byte_cnt = '0;
          col_idx      = '0;
          pix_byte     = '0;
          pix_hold     = '0;
          if (32'(row_idx) + 1 >= image_rows()) dec_phase = PH_TAIL;
          else row_idx++;
        end
      end
    end

    // Final status closes the file and clears the state
    if (last) begin
      if (pos < HEADER_BYTES - 1) fin = ST_SHORT;
      else if (dec_err == ST_SIGNATURE) fin = ST_SIGNATURE;
      else if ({1'b0, pix_offset} > {1'b0, pos} + 33'd1) fin = ST_OFFSET;
      else if (dec_err != ST_OK) fin = dec_err;
      else if (dec_phase != PH_TAIL) fin = ST_TRUNCATED;
      else fin = ST_OK;
      push_result(KIND_STATUS, '0, '0, '0, '0, '0, 1'b0, fin, 1'b1);
      clear_decoder();
    end else if (byte_pos != 32'hFFFF_FFFF) begin
      byte_pos++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic check_result();
    res_t want;
    if (decoded_results.size() == 0) begin
      report_mismatch("result with none outstanding, kind", 32'(out_kind), '0);
      return;
    end
    want = decoded_results.pop_front();
    if (out_kind !== want.kind) report_mismatch("kind", 32'(out_kind), 32'(want.kind));
    if (out_argb !== want.argb) report_mismatch("argb", out_argb, want.argb);
    if (out_pixel_x !== want.pixel_x)
      report_mismatch("pixel_x", 32'(out_pixel_x), 32'(want.pixel_x));
    if (out_pixel_y !== want.pixel_y)
      report_mismatch("pixel_y", 32'(out_pixel_y), 32'(want.pixel_y));
    if (out_image_width !== want.image_width)
      report_mismatch("image_width", 32'(out_image_width), 32'(want.image_width));
    if (out_image_height !== want.image_height)
      report_mismatch("image_height", 32'(out_image_height), 32'(want.image_height));
    if (out_alpha_present !== want.alpha_present)
      report_mismatch("alpha_present", 32'(out_alpha_present), 32'(want.alpha_present));
    if (out_status !== want.status)
      report_mismatch("status", 32'(out_status), 32'(want.status));
    if (out_done_res !== want.done_res)
      report_mismatch("done_res", 32'(out_done_res), 32'(want.done_res));
  endtask

  // Monitor: config, accepted bytes, accepted results, watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fired      <= 1'b0;
      hdr_only_mode = 1'b0;
      quiet_cycles  = 0;
      clear_decoder();
    end else begin
      in_fired <= in_valid && !in_stall;
      if (cfg_wr_en) hdr_only_mode = cfg_wr_data;
      if (in_valid && !in_stall) begin
        decode_byte(in_data_byte, in_last_byte);
        bytes_taken++;
      end
      if (out_valid && !out_stall) check_result();
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL bmp_stream_decoder");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Byte driver: hold the item until taken, then maybe idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= '0;
      in_last_byte <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (file_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = file_bytes.pop_front();
        in_valid     <= 1'b1;
        in_data_byte <= next_byte.data;
        in_last_byte <= next_byte.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    out_stall <= rst_n ? ($urandom_range(99) < recv_idle_pct) : 1'b0;
  end

  // ---------------------------------------------------------------------
  // File construction
  // ---------------------------------------------------------------------

  function automatic int pixel_area(input int width, input int height, input int bpp);
    int row_len;
    row_len = ((width * (bpp / 8)) + 3) & ~3;
    return row_len * (height < 0 ? -height : height);
  endfunction

  // Queue total_len bytes: a header with the given fields, then random body bytes
  task automatic queue_file(input logic [15:0] sig, input logic [31:0] offset,
                            input logic [31:0] width, input logic [31:0] height,
                            input logic [15:0] bpp, input logic [15:0] comp,
                            input int total_len);
    logic [7:0] hdr [HEADER_BYTES];
    byte_item_t it;
    for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom);
    hdr[0] = sig[7:0];
    hdr[1] = sig[15:8];
    for (int i = 0; i < 4; i++) begin
      hdr[OFS_PIXOFF + i] = offset[8*i +: 8];
      hdr[OFS_WIDTH + i]  = width[8*i +: 8];
      hdr[OFS_HEIGHT + i] = height[8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      hdr[OFS_BPP + i]  = bpp[8*i +: 8];
      hdr[OFS_COMP + i] = comp[8*i +: 8];
    end
    for (int i = 0; i < total_len; i++) begin
      it.data = (i < HEADER_BYTES) ? hdr[i] : 8'($urandom);
      it.last = (i == total_len - 1);
      file_bytes.push_back(it);
      bytes_queued++;
    end
  endtask

  // Well-formed image; extra > 0 adds trailing bytes, extra < 0 cuts pixel data
  task automatic queue_image(input int width, input int height, input int bpp,
                             input int gap, input int extra);
    queue_file(SIG_OK, HEADER_BYTES + gap, width, height, 16'(bpp), 16'd0,
               HEADER_BYTES + gap + pixel_area(width, height, bpp) + extra);
  endtask

  // Mostly well-formed files with random content; the rest carry one defect
  task automatic random_file();
    int          pick;
    int          width;
    int          height;
    int          bpp;
    int          gap;
    int          extra;
    int          total;
    logic [15:0] sig;
    logic [15:0] comp;
    logic [31:0] offset;
    logic [31:0] w32;
    logic [31:0] h32;
    pick   = $urandom_range(99);
    width  = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    height = $urandom_range(0, 5);
    if ($urandom_range(1)) height = -height;
    bpp    = $urandom_range(1) ? 32 : 24;
    gap    = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0;
    extra  = 0;
    if (pick < 10) extra = -int'($urandom_range(1, 8));
    else if (pick < 25) extra = $urandom_range(1, 6);
    sig    = SIG_OK;
    comp   = 16'd0;
    offset = HEADER_BYTES + gap;
    w32    = width;
    h32    = height;
    total  = HEADER_BYTES + gap + pixel_area(width, height, bpp) + extra;
    if (pick >= 70) begin
      case ($urandom_range(7))
        0: sig = 16'($urandom);
        1: w32 = $urandom_range(1) ? 32'd0 : 32'($urandom);
        2: h32 = $urandom;
        3: bpp = $urandom_range(0, 40);
        4: comp = 16'($urandom_range(1, 65535));
        5: offset = $urandom_range(0, HEADER_BYTES - 1);
        6: offset = total + $urandom_range(1, 100);
        default: total = $urandom_range(1, HEADER_BYTES);
      endcase
    end
    if (total < 1) total = 1;
    queue_file(sig, offset, w32, h32, 16'(bpp), comp, total);
  endtask

  // Pause the sender until every byte is taken and every result has come
  task automatic wait_drained();
    do @(negedge clk); while (bytes_taken != bytes_queued || decoded_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input logic hdr_only);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hdr_only;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    int target;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    bytes_queued   = 0;
    send_idle_pct  = 20;
    recv_idle_pct  = 85;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed files, full decode
    wait_drained();
    write_mode(1'b0);
    queue_image(3, 2, 24, 0, 0);                        // bottom-up, row padding
    queue_image(2, -3, 32, 6, 0);                       // top-down, gap before pixels
    queue_image(5, 1, 24, 2, 7);                        // trailing bytes after pixels
    queue_image(4, 3, 32, 0, -5);                       // pixel data ends early
    queue_image(1, 0, 24, 0, 3);                        // zero height
    queue_file(SIG_OK, HEADER_BYTES, 2, 2, 24, 0, HEADER_BYTES); // ends on header
    queue_file(SIG_OK, HEADER_BYTES, 1, 1, 24, 0, 1);   // single byte file
    queue_file(SIG_OK, HEADER_BYTES, 1, 1, 24, 0, 30);  // short header
    queue_file(16'h4D41, HEADER_BYTES, 1, 1, 24, 0, 60); // bad first signature byte
    queue_file(16'h4E42, 1000, 1, 1, 24, 0, 60);        // bad second byte beats offset
    queue_file(SIG_OK, HEADER_BYTES, 0, 1, 24, 0, 60);  // zero width
    queue_file(SIG_OK, HEADER_BYTES, 2049, 1, 24, 0, 60);
    queue_file(SIG_OK, HEADER_BYTES, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 60);
    queue_file(SIG_OK, HEADER_BYTES, 1, -2049, 24, 0, 60);
    queue_file(SIG_OK, HEADER_BYTES, 1, 1, 16, 0, 60);  // unsupported depth
    queue_file(SIG_OK, HEADER_BYTES, 1, 1, 24, 16'h0100, 60); // compression high byte
    queue_file(SIG_OK, 40, 1, 1, 32, 0, 60);            // offset inside header
    queue_file(SIG_OK, 32'hFFFF_FFFF, 1, 1, 16, 0, 60); // offset beyond end over depth
    queue_file(SIG_OK, 1000, 1, 0, 24, 0, 70);          // offset beyond end, zero height
    queue_file(SIG_OK, HEADER_BYTES, 2048, -1, 24, 0, HEADER_BYTES + 60); // widest, cut short
    queue_file(SIG_OK, HEADER_BYTES, 1, 2048, 32, 0, HEADER_BYTES + 40); // tallest, cut short

    // Directed files, header only
    wait_drained();
    write_mode(1'b1);
    queue_image(4, 2, 32, 0, 0);
    queue_file(SIG_OK, 500, 3, 3, 24, 0, 60);
    queue_image(2, -2, 24, 0, -10);
    queue_file(SIG_OK, HEADER_BYTES, 2048, -2048, 32, 0, 60); // largest size fields

    // Random files under three idling regimes
    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 20 : (regime == 1) ? 85 : 0;
      recv_idle_pct = (regime == 0) ? 85 : (regime == 1) ? 20 : 0;
      target = bytes_queued + RANDOM_BYTES / 3;
      while (bytes_queued < target) begin
        wait_drained();
        write_mode($urandom_range(3) == 0);
        repeat ($urandom_range(1, 3)) random_file();
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS bmp_stream_decoder");
    end else begin
      $display("FAIL bmp_stream_decoder");
    end
    $finish;
  end

endmodule

`default_nettype wire
